// ===== hdl/rgba_box_downsample_2x2_top_macros.svh =====
`ifndef RGBA_BOX_DOWNSAMPLE_2X2_TOP_MACROS_SVH
`define RGBA_BOX_DOWNSAMPLE_2X2_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RBD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbd assertion failed");

// next-cycle implication
`define RBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbd assertion failed");

`endif

// ===== hdl/rbd_pkg.sv =====
`default_nettype none

package rbd_pkg;

    localparam int DEF_MAX_DIM = 4096;
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 10;
    localparam int NUM_CHAN    = 4;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'd1;

    // channel 0 is red, then green, blue, alpha
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] texel_t;
    typedef logic [NUM_CHAN-1:0][SUM_W-1:0]  sums_t;

    typedef struct packed {
        logic use_mem;
        logic last;
    } quad_ctl_t;

    typedef struct packed {
        logic at_origin;
        logic mem_we;
        logic mem_re;
    } front_stat_t;

    typedef struct packed {
        logic s1_full;
        logic s2_load;
    } back_stat_t;

    function automatic sums_t widen(input texel_t t);
        sums_t r;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            r[c] = SUM_W'(t[c]);
        end
        return r;
    endfunction

    function automatic texel_t round_avg(input sums_t s);
        texel_t r;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            r[c] = CHAN_W'((s[c] + SUM_W'(2)) >> 2);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rbd_in_if.sv =====
`default_nettype none

interface rbd_in_if import rbd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_alpha;

    modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

`default_nettype wire

// ===== hdl/rbd_out_if.sv =====
`default_nettype none

interface rbd_out_if import rbd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              image_done;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, image_done,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, image_done,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/rbd_line_mem.sv =====
`default_nettype none

module rbd_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 40
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/rbd_front.sv =====
`default_nettype none

module rbd_front import rbd_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 accept,
    input  wire texel_t               texel,
    output logic                      have_quad,
    output quad_ctl_t                 ctl,
    output sums_t                     pair,
    output logic                      mem_we,
    output logic                      mem_re,
    output logic [((((MAX_DIM + 1) / 2) > 1) ? $clog2((MAX_DIM + 1) / 2) : 1)-1:0] mem_addr,
    output front_stat_t               stat
);

    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int CNT_W      = $clog2(MAX_DIM);
    localparam int LINE_DEPTH = (MAX_DIM + 1) / 2;
    localparam int X_W        = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CMP_W      = (CFG_W > DIM_W) ? CFG_W : DIM_W;

    logic [DIM_W-1:0] w_reg, h_reg;
    logic [X_W-1:0]   last_x_reg, last_y_reg;
    logic [CNT_W-1:0] col_reg, row_reg;
    texel_t           held_reg;

    logic [DIM_W-1:0] cfg_eff;
    logic [X_W-1:0]   cfg_last;
    logic [CMP_W-1:0] cfg_wide;

    logic [DIM_W-1:0] col_ext, row_ext, w_even, h_even;
    logic             w_one, h_one, col_span, row_span, last_col, last_row;
    logic             have_pair;
    logic [X_W-1:0]   x, y;
    sums_t            wide_in, wide_held;
    logic [CNT_W-1:0] col_next, row_next;

    // out-of-range dimensions clamp to 1 .. MAX_DIM
    always_comb
    begin
        cfg_wide = CMP_W'(cfg_data);
        if (cfg_wide == '0)
        begin
            cfg_eff = DIM_W'(1);
        end
        else if (cfg_wide > CMP_W'(MAX_DIM))
        begin
            cfg_eff = DIM_W'(MAX_DIM);
        end
        else
        begin
            cfg_eff = DIM_W'(cfg_wide);
        end
        cfg_last = (cfg_eff > DIM_W'(1)) ? X_W'((cfg_eff >> 1) - DIM_W'(1)) : '0;
    end

    always_comb
    begin
        col_ext  = DIM_W'(col_reg);
        row_ext  = DIM_W'(row_reg);
        w_even   = {w_reg[DIM_W-1:1], 1'b0};
        h_even   = {h_reg[DIM_W-1:1], 1'b0};
        w_one    = (w_reg == DIM_W'(1));
        h_one    = (h_reg == DIM_W'(1));
        col_span = (col_ext < w_even);
        row_span = (row_ext < h_even);
        last_col = (col_ext == w_reg - DIM_W'(1));
        last_row = (row_ext == h_reg - DIM_W'(1));
        x        = X_W'(col_reg >> 1);
        y        = X_W'(row_reg >> 1);

        wide_in   = widen(texel);
        wide_held = widen(held_reg);
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            pair[c] = w_one ? (wide_in[c] << 1) : (wide_held[c] + wide_in[c]);
        end

        have_pair   = w_one || (col_span && col_reg[0]);
        have_quad   = have_pair && (h_one || (row_span && row_reg[0]));
        ctl.use_mem = !h_one;
        ctl.last    = (x == last_x_reg) && (y == last_y_reg);
        mem_addr    = x;
        mem_we      = accept && have_pair && !h_one && row_span && !row_reg[0];
        mem_re      = accept && have_quad && !h_one;

        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + CNT_W'(1);
        end
        else
        begin
            col_next = col_reg + CNT_W'(1);
            row_next = row_reg;
        end

        stat.at_origin = (col_reg == '0) && (row_reg == '0);
        stat.mem_we    = mem_we;
        stat.mem_re    = mem_re;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg      <= DIM_W'(1);
            h_reg      <= DIM_W'(1);
            last_x_reg <= '0;
            last_y_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            held_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:
                begin
                    w_reg      <= cfg_eff;
                    last_x_reg <= cfg_last;
                end
                REG_SRC_HEIGHT:
                begin
                    h_reg      <= cfg_eff;
                    last_y_reg <= cfg_last;
                end
                default:
                begin
                end
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            // left texel of a pair waits here for its partner
            if (!w_one && col_span && !col_reg[0])
            begin
                held_reg <= texel;
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rbd_back.sv =====
`default_nettype none

module rbd_back import rbd_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      take,
    input  wire quad_ctl_t ctl,
    input  wire sums_t     pair,
    input  wire sums_t     rd_data,
    output logic           s1_free,
    output back_stat_t     stat,
    rbd_out_if.source      dst
);

    logic      s1_valid_reg, s1_valid_next;
    quad_ctl_t s1_ctl_reg;
    sums_t     s1_pair_reg;
    logic      out_valid_reg, out_valid_next;
    texel_t    out_texel_reg;
    logic      out_done_reg;

    logic      s2_load;
    sums_t     quad;

    always_comb
    begin
        s2_load = s1_valid_reg && (!out_valid_reg || dst.ready);
        s1_free = !s1_valid_reg || s2_load;

        s1_valid_next = take ? 1'b1 : (s2_load ? 1'b0 : s1_valid_reg);
        out_valid_next = s2_load ? 1'b1 : (dst.ready ? 1'b0 : out_valid_reg);

        // line store holds the upper row pair; single-row images double the pair
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            quad[c] = s1_ctl_reg.use_mem ? (rd_data[c] + s1_pair_reg[c])
                                         : (s1_pair_reg[c] << 1);
        end

        stat.s1_full = s1_valid_reg;
        stat.s2_load = s2_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_ctl_reg  <= ctl;
            s1_pair_reg <= pair;
        end
        if (s2_load)
        begin
            out_texel_reg <= round_avg(quad);
            out_done_reg  <= s1_ctl_reg.last;
        end
    end

    assign dst.valid      = out_valid_reg;
    assign dst.out_red    = out_texel_reg[0];
    assign dst.out_green  = out_texel_reg[1];
    assign dst.out_blue   = out_texel_reg[2];
    assign dst.out_alpha  = out_texel_reg[3];
    assign dst.image_done = out_done_reg;

endmodule

`default_nettype wire

// ===== hdl/rgba_box_downsample_2x2_top.sv =====
// channel | dir | beat carries
// --------+-----+----------------------------------------------------
// src     | in  | one source texel, raster order (in_red .. in_alpha)
// dst     | out | one destination texel (out_red .. out_alpha, image_done)
// cfg     | in  | register write: cfg_we, cfg_index, cfg_data
//
// one texel per clock sustained while dst takes results; the beat that completes a
// 2x2 block is registered in stage 1 with the line store read, then in the output register
// the line store is a single memory with at most one access per texel: a write on
// even rows, a read on odd rows; it needs no clearing pass after reset
// rst_n clears counters and valid flags; sizes return to 1 x 1
// a stalled dst keeps one result in the output register and one in flight
`default_nettype none

`include "rgba_box_downsample_2x2_top_macros.svh"

module rgba_box_downsample_2x2_top import rbd_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    rbd_in_if.sink                    src,
    rbd_out_if.source                 dst
);

    localparam int LINE_DEPTH = (MAX_DIM + 1) / 2;
    localparam int X_W        = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int LINE_W     = NUM_CHAN * SUM_W;

    logic            accept, have_quad, take, s1_free;
    logic            mem_we, mem_re;
    logic [X_W-1:0]  mem_addr;
    logic [LINE_W-1:0] mem_rdata;
    texel_t          texel;
    quad_ctl_t       ctl;
    sums_t           pair;
    front_stat_t     front_st;
    back_stat_t      back_st;

    assign src.ready = s1_free;
    assign accept    = src.valid && s1_free;
    assign take      = accept && have_quad;
    assign texel     = {src.in_alpha, src.in_blue, src.in_green, src.in_red};

    rbd_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .texel     (texel),
        .have_quad (have_quad),
        .ctl       (ctl),
        .pair      (pair),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .stat      (front_st)
    );

    rbd_line_mem #(
        .DEPTH (LINE_DEPTH),
        .AW    (X_W),
        .DW    (LINE_W)
    ) u_line_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (LINE_W'(pair)),
        .re    (mem_re),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    rbd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .ctl     (ctl),
        .pair    (pair),
        .rd_data (sums_t'(mem_rdata)),
        .s1_free (s1_free),
        .stat    (back_st),
        .dst     (dst)
    );

    `RBD_ASSERT_NEXT(a_cfg_restart, cfg_we, front_st.at_origin)
    `RBD_ASSERT_SAME(a_mem_one_access, front_st.mem_we, !front_st.mem_re)
    `RBD_ASSERT_SAME(a_full_stall, back_st.s1_full && dst.valid && !dst.ready, !src.ready)
    `RBD_ASSERT_NEXT(a_load_shows, back_st.s2_load, dst.valid)

endmodule

`default_nettype wire

// ===== dv/tb_rgba_box_downsample_2x2_top.sv =====
`default_nettype none

module tb_rgba_box_downsample_2x2_top;
    import rbd_pkg::*;

    localparam int LINE_ENTRIES  = DEF_MAX_DIM / 2;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;

    typedef struct packed {
        texel_t rgba;
        logic   done;
    } dst_texel_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    rbd_in_if  src_ch ();
    rbd_out_if dst_ch ();

    rgba_box_downsample_2x2_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src       (src_ch),
        .dst       (dst_ch)
    );

    // mirror of the block state
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      col_pos;
    int unsigned      row_pos;
    texel_t           held_rgba;
    sums_t            pair_line [LINE_ENTRIES];

    dst_texel_t  expected_texels [$];
    int unsigned mismatches;
    int unsigned src_idle_pct;
    int unsigned dst_stall_pct;
    int unsigned hold_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("rgba_box_downsample_2x2_top test failed");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when requested
    initial
    begin
        dst_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                dst_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                dst_ch.ready <= ($urandom_range(99) >= dst_stall_pct);
            end
        end
    end

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > DEF_MAX_DIM)
        begin
            return DEF_MAX_DIM;
        end
        return v;
    endfunction

    function automatic texel_t pack_rgba(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic [7:0] a);
        texel_t t;
        t[0] = r;
        t[1] = g;
        t[2] = b;
        t[3] = a;
        return t;
    endfunction

    function automatic texel_t random_texel();
        texel_t t;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            t[c] = 8'($urandom);
        end
        return t;
    endfunction

    function automatic void predict_downsample(input texel_t t);
        int unsigned w, h, col, row, x, y, dw, dh;
        logic        have_pair, have_quad;
        sums_t       pair, quad;
        dst_texel_t  res;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        col = (col_pos < w) ? col_pos : 0;
        row = (row_pos < h) ? row_pos : 0;
        have_pair = 1'b0;
        have_quad = 1'b0;
        x = 0;
        y = 0;
        pair = '0;
        quad = '0;

        // horizontal taps; a single column doubles itself
        if (w == 1)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                pair[c] = SUM_W'(t[c]) << 1;
            end
            have_pair = 1'b1;
        end
        else if (col < (w / 2) * 2)
        begin
            if (col % 2 == 0)
            begin
                held_rgba = t;
            end
            else
            begin
                for (int c = 0; c < NUM_CHAN; c++)
                begin
                    pair[c] = SUM_W'(held_rgba[c]) + SUM_W'(t[c]);
                end
                x = col / 2;
                have_pair = 1'b1;
            end
        end

        // vertical taps; even rows park their pair sums in the line
        if (have_pair)
        begin
            if (h == 1)
            begin
                for (int c = 0; c < NUM_CHAN; c++)
                begin
                    quad[c] = pair[c] << 1;
                end
                have_quad = 1'b1;
            end
            else if (row < (h / 2) * 2)
            begin
                if (row % 2 == 0)
                begin
                    pair_line[x] = pair;
                end
                else
                begin
                    for (int c = 0; c < NUM_CHAN; c++)
                    begin
                        quad[c] = pair_line[x][c] + pair[c];
                    end
                    y = row / 2;
                    have_quad = 1'b1;
                end
            end
        end

        if (have_quad)
        begin
            dw = (w > 1) ? w / 2 : 1;
            dh = (h > 1) ? h / 2 : 1;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                res.rgba[c] = 8'((int'(quad[c]) + 2) / 4);
            end
            res.done = (x == dw - 1) && (y == dh - 1);
            expected_texels.push_back(res);
        end

        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h)
            begin
                row = 0;
            end
        end
        col_pos = col;
        row_pos = row;
    endfunction

    // called just after a falling edge, returns just after one
    task automatic send_texel(input texel_t t);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            src_ch.valid <= 1'b0;
            @(negedge clk);
        end
        src_ch.valid    <= 1'b1;
        src_ch.in_red   <= t[0];
        src_ch.in_green <= t[1];
        src_ch.in_blue  <= t[2];
        src_ch.in_alpha <= t[3];
        @(posedge clk);
        while (!src_ch.ready)
        begin
            @(posedge clk);
        end
        predict_downsample(t);
        @(negedge clk);
    endtask

    task automatic send_random(input int unsigned n);
        repeat (n)
        begin
            send_texel(random_texel());
        end
    endtask

    // all results in, then let texels that give no result clear the pipe
    task automatic wait_idle();
        src_ch.valid <= 1'b0;
        while (expected_texels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SRC_WIDTH)
        begin
            width_reg = data;
        end
        else
        begin
            height_reg = data;
        end
        col_pos = 0;
        row_pos = 0;
        @(negedge clk);
    endtask

    task automatic test_directed();
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        // 1x1 after reset: each texel is a whole image
        send_texel(pack_rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_texel(pack_rgba(8'h00, 8'h00, 8'h00, 8'h00));
        wait_idle();
        // rounding: channel sums of the top value, 256, 2 and 3
        write_reg(REG_SRC_WIDTH, 13'd2);
        write_reg(REG_SRC_HEIGHT, 13'd2);
        send_texel(pack_rgba(8'hFF, 8'h01, 8'h01, 8'h01));
        send_texel(pack_rgba(8'hFF, 8'h00, 8'h01, 8'h01));
        send_texel(pack_rgba(8'hFF, 8'h00, 8'h00, 8'h01));
        send_texel(pack_rgba(8'hFF, 8'hFF, 8'h00, 8'h00));
        wait_idle();
        // odd width and height drop the last column and row
        write_reg(REG_SRC_WIDTH, 13'd3);
        write_reg(REG_SRC_HEIGHT, 13'd3);
        send_random(9);
        wait_idle();
        // zero width acts as one column
        write_reg(REG_SRC_WIDTH, 13'd0);
        write_reg(REG_SRC_HEIGHT, 13'd2);
        send_texel(pack_rgba(8'h80, 8'h7F, 8'hFF, 8'h00));
        send_texel(pack_rgba(8'h7F, 8'h80, 8'h00, 8'hFF));
        wait_idle();
        // single row with an odd width
        write_reg(REG_SRC_WIDTH, 13'd3);
        write_reg(REG_SRC_HEIGHT, 13'd1);
        send_random(3);
        wait_idle();
    endtask

    task automatic test_restart();
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        write_reg(REG_SRC_WIDTH, 13'd4);
        write_reg(REG_SRC_HEIGHT, 13'd2);
        // part of a row, then a write starts the image over
        send_random(3);
        wait_idle();
        write_reg(REG_SRC_HEIGHT, 13'd2);
        // a row and a half, one result, then another restart
        send_random(6);
        wait_idle();
        write_reg(REG_SRC_WIDTH, 13'd4);
        send_random(8);
        wait_idle();
    endtask

    task automatic test_extreme_sizes();
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        // oversized width clamps; a row prefix gives one result per pair
        write_reg(REG_SRC_WIDTH, 13'h1FFF);
        write_reg(REG_SRC_HEIGHT, 13'd1);
        send_random(128);
        wait_idle();
        src_idle_pct  = 34;
        dst_stall_pct = 34;
        write_reg(REG_SRC_WIDTH, 13'(DEF_MAX_DIM));
        write_reg(REG_SRC_HEIGHT, 13'd1);
        send_random(128);
        wait_idle();
        write_reg(REG_SRC_WIDTH, 13'd0);
        write_reg(REG_SRC_HEIGHT, 13'h1FFF);
        send_random(128);
        wait_idle();
    endtask

    task automatic test_random_images(input int unsigned idle, input int unsigned stall,
                                      input int unsigned budget);
        int unsigned sent, w, h, total;
        logic [CFG_W-1:0] w_val, h_val;
        src_idle_pct  = idle;
        dst_stall_pct = stall;
        sent = 0;
        while (sent < budget)
        begin
            w_val = ($urandom_range(99) < 5) ? 13'($urandom_range(15, 40))
                                              : 13'($urandom_range(0, 14));
            h_val = ($urandom_range(99) < 5) ? 13'($urandom_range(10, 24))
                                              : 13'($urandom_range(0, 9));
            w = eff_dim(w_val);
            h = eff_dim(h_val);
            wait_idle();
            write_reg(REG_SRC_WIDTH, w_val);
            write_reg(REG_SRC_HEIGHT, h_val);
            // back-to-back images exercise the wrap; some are cut short
            total = $urandom_range(1, 3) * w * h;
            if ($urandom_range(99) < 15)
            begin
                total = $urandom_range(1, total);
            end
            send_random(total);
            sent += total;
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        write_reg(REG_SRC_WIDTH, 13'd16);
        write_reg(REG_SRC_HEIGHT, 13'd8);
        @(posedge clk);
        hold_left = 300;
        @(negedge clk);
        send_random(16 * 8 * 2);
        wait_idle();
    endtask

    always @(posedge clk)
    begin
        dst_texel_t want;
        if (rst_n && dst_ch.valid && dst_ch.ready)
        begin
            if (expected_texels.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("dst beat with nothing expected: r %h g %h b %h a %h done %b",
                             dst_ch.out_red, dst_ch.out_green, dst_ch.out_blue,
                             dst_ch.out_alpha, dst_ch.image_done);
                end
                mismatches++;
            end
            else
            begin
                want = expected_texels.pop_front();
                if (dst_ch.out_red !== want.rgba[0] || dst_ch.out_green !== want.rgba[1] ||
                    dst_ch.out_blue !== want.rgba[2] || dst_ch.out_alpha !== want.rgba[3] ||
                    dst_ch.image_done !== want.done)
                begin
                    if (mismatches < 10)
                    begin
                        $display("dst mismatch: expected r %h g %h b %h a %h done %b",
                                 want.rgba[0], want.rgba[1], want.rgba[2], want.rgba[3],
                                 want.done);
                        $display("              actual   r %h g %h b %h a %h done %b",
                                 dst_ch.out_red, dst_ch.out_green, dst_ch.out_blue,
                                 dst_ch.out_alpha, dst_ch.image_done);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        src_ch.valid    = 1'b0;
        src_ch.in_red   = '0;
        src_ch.in_green = '0;
        src_ch.in_blue  = '0;
        src_ch.in_alpha = '0;
        src_idle_pct    = 0;
        dst_stall_pct   = 0;
        hold_left       = 0;
        mismatches      = 0;
        width_reg       = 13'd1;
        height_reg      = 13'd1;
        col_pos         = 0;
        row_pos         = 0;
        held_rgba       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_restart();
        test_extreme_sizes();
        test_random_images(0, 0, 270);
        test_random_images(72, 0, 270);
        test_random_images(0, 72, 270);
        test_backpressure();
        test_random_images(34, 34, 270);

        src_ch.valid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && expected_texels.size() != 0; i++)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_texels.size() == 0)
        begin
            $display("rgba_box_downsample_2x2_top test passed");
        end
        else
        begin
            $display("rgba_box_downsample_2x2_top test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
